// ===== rtl/kmc_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the k-means block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kmc_pkg;

  localparam int MAX_POINTS     = 1024;
  localparam int MAX_DIM        = 8;
  localparam int MAX_COMPONENTS = 8;

  localparam int PT_DEPTH = MAX_POINTS * MAX_DIM;
  localparam int MN_DEPTH = MAX_COMPONENTS * MAX_DIM;
  localparam int PT_AW    = $clog2(PT_DEPTH);
  localparam int MN_AW    = $clog2(MN_DEPTH);

  localparam int K_W       = 3;
  localparam int D_W       = 3;
  localparam int NP_W      = 11;
  localparam int DIM_W     = 4;
  localparam int NC_W      = 4;
  localparam int IT_W      = 8;
  localparam int TOL_W     = 31;
  localparam int IDX_W     = 13;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 11;
  localparam int SQ_W      = 66;
  localparam int ACC_W     = 68;
  localparam int ROOT_W    = 36;
  localparam int SHIFT_W   = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 31;

  localparam logic [1:0] MODE_LOAD_POINT = 2'd0;
  localparam logic [1:0] MODE_LOAD_MEAN  = 2'd1;
  localparam logic [1:0] MODE_RUN        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_DIM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COMPONENTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 3'd4;

  typedef struct packed {
    logic [NP_W-1:0]  num_points;
    logic [DIM_W-1:0] point_dim;
    logic [NC_W-1:0]  num_components;
    logic [IT_W-1:0]  max_iterations;
    logic [TOL_W-1:0] tolerance;
  } cfg_t;

  typedef struct packed {
    logic             ld_pt_we;
    logic             ld_mn_we;
    logic             pt_rd;
    logic [PT_AW-1:0] pt_addr;
    logic             mn_rd;
    logic [MN_AW-1:0] mn_addr;
    logic             fresh_we;
    logic             sum_rd;
    logic             sum_clr_we;
    logic             sum_acc_we;
    logic [MN_AW-1:0] sum_addr;
    logic             cnt_clr;
    logic             cnt_inc;
    logic [K_W-1:0]   cnt_k;
    logic             sq_load;
    logic             sq_sel_fresh;
    logic             acc_clr;
    logic             acc_add;
    logic             best_take;
    logic             div_start;
    logic             fresh_from_old;
    logic             sqrt_start;
    logic             shift_clr;
    logic             out_load;
    logic [K_W-1:0]   out_cluster;
    logic [D_W-1:0]   out_dim;
    logic             out_last;
    logic [IT_W-1:0]  out_passes;
    logic [NC_W-1:0]  comps;
  } cmd_t;

  typedef struct packed {
    logic closer;
    logic count_zero;
    logic div_busy;
    logic sqrt_busy;
    logic stop_ok;
    logic out_valid;
  } status_t;

endpackage

// ===== rtl/kmc_div.sv =====
// bit-serial signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
// depends on kmc_pkg
`timescale 1ns / 1ps

module kmc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kmc_pkg::SUM_W-1:0]   dividend,
  input  logic [kmc_pkg::CNT_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [kmc_pkg::VAL_W-1:0]   quotient
);
  import kmc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  q;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dvs;
  logic              neg;

  logic [CNT_W:0]    trial;
  logic              ge;
  logic [CNT_W:0]    rem_next;
  logic [SUM_W-1:0]  q_next;
  logic [SUM_W-1:0]  mag;

  always_comb begin
    mag      = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    trial    = {rem[CNT_W-1:0], q[SUM_W-1]};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? (trial - {1'b0, dvs}) : trial;
    q_next   = {q[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        q    <= mag;
        rem  <= '0;
        dvs  <= divisor;
        neg  <= dividend[SUM_W-1];
      end else if (busy) begin
        q    <= q_next;
        rem  <= rem_next;
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? (~q_next[VAL_W-1:0] + 1'b1) : q_next[VAL_W-1:0];
        end
      end
    end
  end

endmodule

// ===== rtl/kmc_sqrt.sv =====
// digit-by-digit integer square root, two radicand bits per cycle, floor result
// depends on kmc_pkg
`timescale 1ns / 1ps

module kmc_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kmc_pkg::ACC_W-1:0]   radicand,
  output logic                        busy,
  output logic                        done,
  output logic [kmc_pkg::ROOT_W-1:0]  root
);
  import kmc_pkg::*;

  localparam int V_W    = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 4;
  localparam int STEP_W = $clog2(ROOT_W);

  logic [STEP_W-1:0] step;
  logic [V_W-1:0]    v;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] acc_root;

  logic [REM_W-1:0]  r4;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic [ROOT_W-1:0] root_next;

  always_comb begin
    r4        = {rem[REM_W-3:0], v[V_W-1 -: 2]};
    trial     = {{(REM_W-ROOT_W-2){1'b0}}, acc_root, 2'b01};
    ge        = (r4 >= trial);
    root_next = {acc_root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        v        <= {{(V_W-ACC_W){1'b0}}, radicand};
        rem      <= '0;
        acc_root <= '0;
      end else if (busy) begin
        v        <= {v[V_W-3:0], 2'b00};
        rem      <= ge ? (r4 - trial) : r4;
        acc_root <= root_next;
        step     <= step + 1'b1;
        if (step == STEP_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          root <= root_next;
        end
      end
    end
  end

endmodule

// ===== rtl/kmc_datapath.sv =====
// stores, distance accumulator, cluster sums and counts, divider, square root and output register
// depends on kmc_pkg, kmc_div and kmc_sqrt
`timescale 1ns / 1ps

module kmc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  kmc_pkg::cmd_t               cmd,
  input  logic [kmc_pkg::TOL_W-1:0]   tolerance,
  input  logic [kmc_pkg::IDX_W-1:0]   element_index,
  input  logic [kmc_pkg::VAL_W-1:0]   coord_value,
  input  logic                        out_ready,
  output kmc_pkg::status_t            st,
  output logic [kmc_pkg::K_W-1:0]     cluster_index,
  output logic [kmc_pkg::D_W-1:0]     dim_index,
  output logic [kmc_pkg::VAL_W-1:0]   mean_value,
  output logic [kmc_pkg::IT_W-1:0]    passes_done,
  output logic                        last
);
  import kmc_pkg::*;

  logic [VAL_W-1:0] pt_mem [PT_DEPTH];
  logic [VAL_W-1:0] mn_mem [MN_DEPTH];
  logic [SUM_W-1:0] sum_mem [MN_DEPTH];

  logic [VAL_W-1:0] pt_q;
  logic [VAL_W-1:0] mn_q;
  logic [SUM_W-1:0] sums_q;
  logic [VAL_W-1:0] fresh;

  logic [CNT_W-1:0] counts [MAX_COMPONENTS];
  logic [CNT_W-1:0] count_sel;

  logic [SQ_W-1:0]    sq;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   bestd;
  logic [SHIFT_W-1:0] shift_sum;
  logic               out_valid;

  logic [VAL_W-1:0]  sq_a;
  logic [VAL_W:0]    diff;
  logic [VAL_W:0]    mag;
  logic [SQ_W-1:0]   sq_next;
  logic [VAL_W-1:0]  tol_p1;
  logic [VAL_W+NC_W-1:0] limit;
  logic              mn_ld_ok;

  logic              div_busy;
  logic              div_done;
  logic [VAL_W-1:0]  div_q;
  logic              sqrt_busy;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  // mean loads past the mean store are dropped
  assign mn_ld_ok = (element_index[IDX_W-1:MN_AW] == '0);

  always_ff @(posedge clk) begin
    if (cmd.ld_pt_we) pt_mem[element_index[PT_AW-1:0]] <= coord_value;
    if (cmd.pt_rd) pt_q <= pt_mem[cmd.pt_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_mn_we && mn_ld_ok) begin
      mn_mem[element_index[MN_AW-1:0]] <= coord_value;
    end else if (cmd.fresh_we) begin
      mn_mem[cmd.mn_addr] <= fresh;
    end
    if (cmd.mn_rd) mn_q <= mn_mem[cmd.mn_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clr_we) begin
      sum_mem[cmd.sum_addr] <= '0;
    end else if (cmd.sum_acc_we) begin
      sum_mem[cmd.sum_addr] <= sums_q + {{(SUM_W-VAL_W){pt_q[VAL_W-1]}}, pt_q};
    end
    if (cmd.sum_rd) sums_q <= sum_mem[cmd.sum_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      for (int c = 0; c < MAX_COMPONENTS; c++) counts[c] <= '0;
    end else if (cmd.cnt_inc) begin
      counts[cmd.cnt_k] <= counts[cmd.cnt_k] + 1'b1;
    end
  end

  assign count_sel = counts[cmd.cnt_k];

  // squared coordinate difference, exact in 66 bits
  always_comb begin
    sq_a    = cmd.sq_sel_fresh ? fresh : pt_q;
    diff    = {sq_a[VAL_W-1], sq_a} - {mn_q[VAL_W-1], mn_q};
    mag     = diff[VAL_W] ? (~diff + 1'b1) : diff;
    sq_next = mag * mag;
    tol_p1  = {1'b0, tolerance} + 1'b1;
    limit   = tol_p1 * cmd.comps;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_load) sq <= sq_next;
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + {{(ACC_W-SQ_W){1'b0}}, sq};
    end
    if (cmd.best_take) bestd <= acc;
    if (cmd.fresh_from_old) begin
      fresh <= mn_q;
    end else if (div_done) begin
      fresh <= div_q;
    end
    if (cmd.shift_clr) begin
      shift_sum <= '0;
    end else if (sqrt_done) begin
      shift_sum <= shift_sum + {{(SHIFT_W-ROOT_W){1'b0}}, sqrt_root};
    end
  end

  kmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sums_q),
    .divisor  (count_sel),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  kmc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (acc),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid     <= 1'b1;
      cluster_index <= cmd.out_cluster;
      dim_index     <= cmd.out_dim;
      mean_value    <= mn_q;
      passes_done   <= cmd.out_passes;
      last          <= cmd.out_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    st.closer     = (acc < bestd);
    st.count_zero = (count_sel == '0);
    st.div_busy   = div_busy;
    st.sqrt_busy  = sqrt_busy;
    // floor(shift_sum / comps) <= tol  is  shift_sum < (tol + 1) * comps
    st.stop_ok    = (shift_sum < {{(SHIFT_W-VAL_W-NC_W){1'b0}}, limit});
    st.out_valid  = out_valid;
  end

endmodule

// ===== rtl/kmc_ctrl.sv =====
// sequencer for loads, assignment pass, mean update, convergence test and emission
// depends on kmc_pkg
`timescale 1ns / 1ps

module kmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  kmc_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic [1:0]          mode,
  output logic                in_ready,
  input  kmc_pkg::status_t    st,
  output kmc_pkg::cmd_t       cmd
);
  import kmc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_DRD, S_DSQ, S_DACC, S_DBEST, S_SRD, S_SWR,
    S_URD, S_UDIV, S_UWAIT, S_USQ, S_UACC, S_USQRT, S_USWAIT, S_UEND,
    S_ERD, S_ELD
  } state_t;

  state_t state;

  logic [NP_W-1:0]  i;
  logic [PT_AW-1:0] pbase;
  logic [K_W-1:0]   k;
  logic [MN_AW-1:0] mbase;
  logic [D_W-1:0]   d;
  logic [K_W-1:0]   best_k;
  logic [MN_AW-1:0] best_base;
  logic [IT_W-1:0]  passes;
  logic [MN_AW-1:0] clr;

  logic [NP_W-1:0]  n_c;
  logic [DIM_W-1:0] dim_c;
  logic [NC_W-1:0]  comps_c;
  logic             last_d;
  logic             last_k;
  logic             last_i;
  logic             take;
  logic [IT_W-1:0]  passes_inc;

  always_comb begin
    if (cfg.num_points == '0) n_c = NP_W'(1);
    else if (cfg.num_points > NP_W'(MAX_POINTS)) n_c = NP_W'(MAX_POINTS);
    else n_c = cfg.num_points;
    if (cfg.point_dim == '0) dim_c = DIM_W'(1);
    else if (cfg.point_dim > DIM_W'(MAX_DIM)) dim_c = DIM_W'(MAX_DIM);
    else dim_c = cfg.point_dim;
    if (cfg.num_components == '0) comps_c = NC_W'(1);
    else if (cfg.num_components > NC_W'(MAX_COMPONENTS)) comps_c = NC_W'(MAX_COMPONENTS);
    else comps_c = cfg.num_components;
    last_d     = ({1'b0, d} == dim_c - 1'b1);
    last_k     = ({1'b0, k} == comps_c - 1'b1);
    last_i     = (i == n_c - 1'b1);
    // ties keep the lower cluster
    take       = (k == '0) || st.closer;
    passes_inc = passes + 1'b1;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.comps       = comps_c;
    cmd.out_cluster = k;
    cmd.out_dim     = d;
    cmd.out_last    = last_k && last_d;
    cmd.out_passes  = passes;
    cmd.cnt_k       = (state == S_SWR) ? best_k : k;
    case (state)
      S_IDLE: begin
        cmd.ld_pt_we = in_valid && (mode == MODE_LOAD_POINT);
        cmd.ld_mn_we = in_valid && (mode == MODE_LOAD_MEAN);
      end
      S_CLR: begin
        cmd.sum_clr_we = 1'b1;
        cmd.sum_addr   = clr;
        cmd.cnt_clr    = 1'b1;
        cmd.acc_clr    = 1'b1;
      end
      S_DRD: begin
        cmd.pt_rd   = 1'b1;
        cmd.pt_addr = pbase + PT_AW'(d);
        cmd.mn_rd   = 1'b1;
        cmd.mn_addr = mbase + MN_AW'(d);
      end
      S_DSQ:  cmd.sq_load = 1'b1;
      S_DACC: cmd.acc_add = 1'b1;
      S_DBEST: begin
        cmd.best_take = take;
        cmd.acc_clr   = 1'b1;
      end
      S_SRD: begin
        cmd.pt_rd    = 1'b1;
        cmd.pt_addr  = pbase + PT_AW'(d);
        cmd.sum_rd   = 1'b1;
        cmd.sum_addr = best_base + MN_AW'(d);
      end
      S_SWR: begin
        cmd.sum_acc_we = 1'b1;
        cmd.sum_addr   = best_base + MN_AW'(d);
        cmd.cnt_inc    = last_d;
        cmd.shift_clr  = last_d && last_i;
      end
      S_URD: begin
        cmd.mn_rd    = 1'b1;
        cmd.mn_addr  = mbase + MN_AW'(d);
        cmd.sum_rd   = 1'b1;
        cmd.sum_addr = mbase + MN_AW'(d);
      end
      S_UDIV: begin
        cmd.fresh_from_old = st.count_zero;
        cmd.div_start      = !st.count_zero;
      end
      S_USQ: begin
        // old mean was read already, so the new one goes back in place
        cmd.fresh_we     = 1'b1;
        cmd.mn_addr      = mbase + MN_AW'(d);
        cmd.sq_load      = 1'b1;
        cmd.sq_sel_fresh = 1'b1;
      end
      S_UACC:   cmd.acc_add    = 1'b1;
      S_USQRT:  cmd.sqrt_start = 1'b1;
      S_USWAIT: cmd.acc_clr    = !st.sqrt_busy;
      S_ERD: begin
        cmd.mn_rd   = !st.out_valid;
        cmd.mn_addr = mbase + MN_AW'(d);
      end
      S_ELD:  cmd.out_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      passes <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && (mode == MODE_RUN)) begin
            passes <= '0;
            k      <= '0;
            d      <= '0;
            mbase  <= '0;
            clr    <= '0;
            state  <= (cfg.max_iterations == '0) ? S_ERD : S_CLR;
          end
        end
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == MN_AW'(MN_DEPTH - 1)) begin
            i     <= '0;
            pbase <= '0;
            k     <= '0;
            mbase <= '0;
            d     <= '0;
            state <= S_DRD;
          end
        end
        S_DRD: state <= S_DSQ;
        S_DSQ: state <= S_DACC;
        S_DACC: begin
          if (last_d) begin
            state <= S_DBEST;
          end else begin
            d     <= d + 1'b1;
            state <= S_DRD;
          end
        end
        S_DBEST: begin
          if (take) begin
            best_k    <= k;
            best_base <= mbase;
          end
          d <= '0;
          if (last_k) begin
            state <= S_SRD;
          end else begin
            k     <= k + 1'b1;
            mbase <= mbase + MN_AW'(dim_c);
            state <= S_DRD;
          end
        end
        S_SRD: state <= S_SWR;
        S_SWR: begin
          if (!last_d) begin
            d     <= d + 1'b1;
            state <= S_SRD;
          end else begin
            d     <= '0;
            k     <= '0;
            mbase <= '0;
            if (last_i) begin
              state <= S_URD;
            end else begin
              i     <= i + 1'b1;
              pbase <= pbase + PT_AW'(dim_c);
              state <= S_DRD;
            end
          end
        end
        S_URD: state <= S_UDIV;
        S_UDIV: state <= st.count_zero ? S_USQ : S_UWAIT;
        S_UWAIT: begin
          if (!st.div_busy) state <= S_USQ;
        end
        S_USQ: state <= S_UACC;
        S_UACC: begin
          if (last_d) begin
            state <= S_USQRT;
          end else begin
            d     <= d + 1'b1;
            state <= S_URD;
          end
        end
        S_USQRT: state <= S_USWAIT;
        S_USWAIT: begin
          if (!st.sqrt_busy) begin
            d <= '0;
            if (last_k) begin
              state <= S_UEND;
            end else begin
              k     <= k + 1'b1;
              mbase <= mbase + MN_AW'(dim_c);
              state <= S_URD;
            end
          end
        end
        S_UEND: begin
          passes <= passes_inc;
          k      <= '0;
          d      <= '0;
          mbase  <= '0;
          clr    <= '0;
          if (st.stop_ok || (passes_inc == cfg.max_iterations)) state <= S_ERD;
          else state <= S_CLR;
        end
        S_ERD: begin
          if (!st.out_valid) state <= S_ELD;
        end
        S_ELD: begin
          if (last_k && last_d) begin
            state <= S_IDLE;
          end else if (last_d) begin
            d     <= '0;
            k     <= k + 1'b1;
            mbase <= mbase + MN_AW'(dim_c);
            state <= S_ERD;
          end else begin
            d     <= d + 1'b1;
            state <= S_ERD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/kmeans_cluster_means_top.sv =====
// Lloyd k-means block: config registers, sequencer and datapath
// depends on kmc_pkg, kmc_ctrl and kmc_datapath
`timescale 1ns / 1ps

// Point and mean loads are taken one request per cycle while the block is idle and give no
// result. A run request occupies the block until its last mean coordinate has been loaded
// into the output register. Each pass clears all 64 cluster sum entries, then per point
// runs the distance search and accumulation, then per cluster the mean update with the
// one-bit-per-cycle divider (skipped for empty clusters) and the two-bits-per-cycle square
// root. Emission then loads one coordinate at a time, waiting while the output side stalls.
// All point and mean store accesses go through single read ports, one per cycle.
module kmeans_cluster_means_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kmc_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      mode,
  input  logic [kmc_pkg::IDX_W-1:0]       element_index,
  input  logic signed [kmc_pkg::VAL_W-1:0] coord_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kmc_pkg::K_W-1:0]         cluster_index,
  output logic [kmc_pkg::D_W-1:0]         dim_index,
  output logic signed [kmc_pkg::VAL_W-1:0] mean_value,
  output logic [kmc_pkg::IT_W-1:0]        passes_done,
  output logic                            last
);
  import kmc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_points     <= NP_W'(1024);
      cfg.point_dim      <= DIM_W'(8);
      cfg.num_components <= NC_W'(8);
      cfg.max_iterations <= IT_W'(20);
      cfg.tolerance      <= TOL_W'(66);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_POINTS:     cfg.num_points     <= cfg_data[NP_W-1:0];
        REG_POINT_DIM:      cfg.point_dim      <= cfg_data[DIM_W-1:0];
        REG_NUM_COMPONENTS: cfg.num_components <= cfg_data[NC_W-1:0];
        REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[IT_W-1:0];
        REG_TOLERANCE:      cfg.tolerance      <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  kmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  kmc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .tolerance     (cfg.tolerance),
    .element_index (element_index),
    .coord_value   (coord_value),
    .out_ready     (out_ready),
    .st            (st),
    .cluster_index (cluster_index),
    .dim_index     (dim_index),
    .mean_value    (mean_value),
    .passes_done   (passes_done),
    .last          (last)
  );

  assign out_valid = st.out_valid;

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(st.div_busy && st.sqrt_busy))
    else $error("divider and square root busy together");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !st.div_busy)
    else $error("divider restarted while busy");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!st.div_busy && !st.sqrt_busy))
    else $error("request taken while a unit is busy");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid)
    else $error("result register overwritten");

endmodule

// ===== dv/kmc_checker.sv =====
// checker for the k-means block: follows config writes and requests, predicts mean coordinates
// depends on kmc_pkg; instantiated beside the block by tb_kmeans_cluster_means_top
`timescale 1ns / 1ps

module kmc_checker
  import kmc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              mode,
  input  logic [IDX_W-1:0]        element_index,
  input  logic signed [VAL_W-1:0] coord_value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [K_W-1:0]          cluster_index,
  input  logic [D_W-1:0]          dim_index,
  input  logic signed [VAL_W-1:0] mean_value,
  input  logic [IT_W-1:0]         passes_done,
  input  logic                    last,
  output int                      errors,
  output int                      pending,
  output int                      runs_seen,
  output int                      coords_seen
);

  typedef struct {
    logic [K_W-1:0]   k;
    logic [D_W-1:0]   d;
    logic [VAL_W-1:0] v;
    logic [IT_W-1:0]  p;
    logic             l;
  } mean_coord_t;

  mean_coord_t means_due[$];
  int pt_mem[PT_DEPTH];
  int mn_mem[MN_DEPTH];
  cfg_t cfg;

  assign pending = means_due.size();

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // exact squared distance, differences up to 33 bits so 80 bits is plenty
  function automatic logic [79:0] gap_sq(input int a[MAX_DIM], input int b[MAX_DIM],
                                         input int unsigned n);
    logic [79:0] acc;
    logic [79:0] mag;
    longint diff;
    acc = '0;
    for (int unsigned d = 0; d < n; d++) begin
      diff = longint'(a[d]) - longint'(b[d]);
      mag = (diff < 0) ? 80'(-diff) : 80'(diff);
      acc += mag * mag;
    end
    return acc;
  endfunction

  function automatic logic [79:0] floor_root(input logic [79:0] v);
    logic [79:0] r;
    logic [79:0] c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (80'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  task automatic predict_means();
    int unsigned n, dm, kc, best, passes, e;
    int pa[MAX_DIM];
    int pb[MAX_DIM];
    int fresh[MN_DEPTH];
    longint sums[MN_DEPTH];
    int unsigned cnt[MAX_COMPONENTS];
    logic [79:0] bestd, dk;
    longint unsigned shift_sum;
    mean_coord_t mc;
    n  = clamp_size(cfg.num_points, MAX_POINTS);
    dm = clamp_size(cfg.point_dim, MAX_DIM);
    kc = clamp_size(cfg.num_components, MAX_COMPONENTS);
    passes = 0;
    while (passes < cfg.max_iterations) begin
      foreach (sums[j]) sums[j] = 0;
      foreach (cnt[j]) cnt[j] = 0;
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned d = 0; d < dm; d++) pa[d] = pt_mem[i * dm + d];
        best = 0;
        for (int unsigned k = 0; k < kc; k++) begin
          for (int unsigned d = 0; d < dm; d++) pb[d] = mn_mem[k * dm + d];
          dk = gap_sq(pa, pb, dm);
          // strict compare keeps ties on the lowest cluster
          if (k == 0 || dk < bestd) begin
            bestd = dk;
            best = k;
          end
        end
        for (int unsigned d = 0; d < dm; d++) sums[best * dm + d] += longint'(pa[d]);
        cnt[best]++;
      end
      shift_sum = 0;
      for (int unsigned k = 0; k < kc; k++) begin
        for (int unsigned d = 0; d < dm; d++) begin
          e = k * dm + d;
          fresh[e] = (cnt[k] == 0) ? mn_mem[e] : int'(sums[e] / longint'(cnt[k]));
          pa[d] = fresh[e];
          pb[d] = mn_mem[e];
        end
        shift_sum += longint'(floor_root(gap_sq(pa, pb, dm)));
      end
      for (int unsigned j = 0; j < kc * dm; j++) mn_mem[j] = fresh[j];
      passes++;
      if (shift_sum / kc <= longint'(cfg.tolerance)) break;
    end
    for (int unsigned k = 0; k < kc; k++) begin
      for (int unsigned d = 0; d < dm; d++) begin
        mc.k = k[K_W-1:0];
        mc.d = d[D_W-1:0];
        mc.v = mn_mem[k * dm + d];
        mc.p = passes[IT_W-1:0];
        mc.l = (k + 1 == kc) && (d + 1 == dm);
        means_due.push_back(mc);
      end
    end
  endtask

  always @(posedge clk) begin
    mean_coord_t want;
    if (rst) begin
      cfg.num_points     = 11'd1024;
      cfg.point_dim      = 4'd8;
      cfg.num_components = 4'd8;
      cfg.max_iterations = 8'd20;
      cfg.tolerance      = 31'd66;
      means_due.delete();
      errors      = 0;
      runs_seen   = 0;
      coords_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_POINTS:     cfg.num_points     = cfg_data[NP_W-1:0];
          REG_POINT_DIM:      cfg.point_dim      = cfg_data[DIM_W-1:0];
          REG_NUM_COMPONENTS: cfg.num_components = cfg_data[NC_W-1:0];
          REG_MAX_ITERATIONS: cfg.max_iterations = cfg_data[IT_W-1:0];
          REG_TOLERANCE:      cfg.tolerance      = cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (mode)
          MODE_LOAD_POINT: if (element_index < PT_DEPTH) pt_mem[element_index] = coord_value;
          MODE_LOAD_MEAN:  if (element_index < MN_DEPTH) mn_mem[element_index] = coord_value;
          MODE_RUN: begin
            predict_means();
            runs_seen++;
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        coords_seen++;
        if (means_due.size() == 0) begin
          $error("unexpected mean coordinate k=%0d d=%0d", cluster_index, dim_index);
          errors++;
        end else begin
          want = means_due.pop_front();
          if (cluster_index !== want.k) begin
            $error("cluster_index expected %0d actual %0d", want.k, cluster_index);
            errors++;
          end
          if (dim_index !== want.d) begin
            $error("dim_index expected %0d actual %0d", want.d, dim_index);
            errors++;
          end
          if (mean_value !== want.v) begin
            $error("mean_value expected %h actual %h", want.v, mean_value);
            errors++;
          end
          if (passes_done !== want.p) begin
            $error("passes_done expected %0d actual %0d", want.p, passes_done);
            errors++;
          end
          if (last !== want.l) begin
            $error("last expected %0d actual %0d", want.l, last);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_kmeans_cluster_means_top.sv =====
// top of the k-means testbench: clock, reset, config phases, load and run requests
// depends on kmc_pkg, kmeans_cluster_means_top and kmc_checker
`timescale 1ns / 1ps

module tb_kmeans_cluster_means_top;
  import kmc_pkg::*;

  localparam int QUIET_LIMIT  = 400000;
  localparam int ITEMS_WANTED = 400;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DAT_W-1:0]    cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              mode;
  logic [IDX_W-1:0]        element_index;
  logic signed [VAL_W-1:0] coord_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [K_W-1:0]          cluster_index;
  logic [D_W-1:0]          dim_index;
  logic signed [VAL_W-1:0] mean_value;
  logic [IT_W-1:0]         passes_done;
  logic                    last;

  int errors, pending, runs_seen, coords_seen;
  int snd_idle, rcv_idle, stall_left, items_sent, quiet, base_sent;
  logic req_taken;

  kmeans_cluster_means_top dut (.*);

  kmc_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .mode,
    .element_index, .coord_value, .out_valid, .out_ready, .cluster_index, .dim_index,
    .mean_value, .passes_done, .last, .errors, .pending, .runs_seen, .coords_seen
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) req_taken <= in_valid && in_ready;

  // receiver: random stalls, plus a long hold-off when stall_left is loaded
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return int'($urandom_range(6)) * 32'sh40000 + int'($urandom_range(131071)) - 65536;
  endfunction

  task automatic send_req(input logic [1:0] m, input int unsigned idx, input logic [31:0] v);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    element_index <= idx[IDX_W-1:0];
    coord_value   <= v;
    do @(negedge clk); while (!req_taken);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cfg(input int np, input int dm, input int nc, input int it,
                           input int tol);
    logic [CFG_IDX_W-1:0] regs[5];
    int vals[5];
    regs = '{REG_NUM_POINTS, REG_POINT_DIM, REG_NUM_COMPONENTS, REG_MAX_ITERATIONS,
             REG_TOLERANCE};
    vals = '{np, dm, nc, it, tol};
    for (int j = 0; j < 5; j++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[j];
      cfg_data  <= vals[j][CFG_DAT_W-1:0];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned eff(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // one config setting: fresh stores, then the given number of runs with noise and reloads between
  task automatic run_phase(input int np, input int dm, input int nc, input int it,
                           input int tol, input int runs);
    int unsigned n, d, k;
    wait_idle();
    write_cfg(np, dm, nc, it, tol);
    n = eff(np & 11'h7ff, MAX_POINTS);
    d = eff(dm & 4'hf, MAX_DIM);
    k = eff(nc & 4'hf, MAX_COMPONENTS);
    for (int unsigned j = 0; j < n * d; j++) send_req(MODE_LOAD_POINT, j, rand_coord());
    for (int unsigned j = 0; j < k * d; j++) send_req(MODE_LOAD_MEAN, j, rand_coord());
    for (int r = 0; r < runs; r++) begin
      send_req(MODE_RUN, $urandom_range(8191), $urandom);
      repeat ($urandom_range(3)) begin
        case ($urandom_range(3))
          0: send_req(2'd3, $urandom_range(8191), $urandom);
          1: send_req(MODE_LOAD_MEAN, $urandom_range(8191, MN_DEPTH), $urandom);
          default: send_req(MODE_LOAD_POINT, $urandom_range(n * d - 1), rand_coord());
        endcase
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_LOAD_POINT;
    element_index = '0;
    coord_value = '0;
    out_ready = 1'b0;
    stall_left = 0;
    snd_idle = 37;
    rcv_idle = 77;
    items_sent = 0;
    base_sent = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // extremes, a tie between identical means (one stays empty), ignored requests
    write_cfg(4, 2, 3, 5, 0);
    send_req(MODE_LOAD_POINT, 0, 32'h7fffffff);
    send_req(MODE_LOAD_POINT, 1, 32'h80000000);
    send_req(MODE_LOAD_POINT, 2, 32'hffffffff);
    send_req(MODE_LOAD_POINT, 3, 32'h0);
    send_req(MODE_LOAD_POINT, 4, 32'h0);
    send_req(MODE_LOAD_POINT, 5, 32'h0);
    send_req(MODE_LOAD_POINT, 6, 32'h80000000);
    send_req(MODE_LOAD_POINT, 7, 32'h7fffffff);
    send_req(MODE_LOAD_MEAN, 0, 32'h0);
    send_req(MODE_LOAD_MEAN, 1, 32'h0);
    send_req(MODE_LOAD_MEAN, 2, 32'h0);
    send_req(MODE_LOAD_MEAN, 3, 32'h0);
    send_req(MODE_LOAD_MEAN, 4, 32'h7fffffff);
    send_req(MODE_LOAD_MEAN, 5, 32'h7fffffff);
    send_req(MODE_RUN, 0, 32'h0);
    send_req(2'd3, 8191, 32'hffffffff);
    send_req(MODE_LOAD_MEAN, 8191, 32'h12345678);
    send_req(MODE_RUN, 8191, 32'hffffffff);
    wait_idle();
    // zero iteration limit: current means come out untouched
    write_cfg(4, 2, 3, 0, 66);
    send_req(MODE_RUN, 0, 32'h0);

    // saturating sizes and register extremes
    run_phase(5, 1, 1, 1, 66, 1);
    run_phase(0, 0, 0, 255, 0, 2);
    run_phase(3, 15, 15, 3, 32'h7fffffff, 2);
    run_phase(4, 1, 2, 255, 0, 2);
    run_phase(9, 1, 8, 1, 0, 1);

    // long receiver hold-off while runs keep queuing behind the output
    snd_idle = 0;
    wait_idle();
    stall_left = 3000;
    run_phase(6, 2, 3, 2, 66, 4);

    base_sent = items_sent;
    while (items_sent < ITEMS_WANTED) begin
      if (items_sent < base_sent + (ITEMS_WANTED - base_sent) / 3) begin
        snd_idle = 37;
        rcv_idle = 77;
      end else if (items_sent < base_sent + 2 * (ITEMS_WANTED - base_sent) / 3) begin
        snd_idle = 77;
        rcv_idle = 37;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      run_phase($urandom_range(12, 1), $urandom_range(4, 1), $urandom_range(4, 1),
                $urandom_range(6, 1), $urandom_range(3) == 0 ? $urandom_range(200000) : 66,
                $urandom_range(4, 1));
    end

    wait_idle();
    repeat (60) @(negedge clk);
    $display("covered %0d requests, %0d clustering runs, %0d mean coordinates checked",
             items_sent, runs_seen, coords_seen);
    $display("sizes and limits swept through saturation, zero iterations and max tolerance");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
